[rtl/lsgp_pkg.sv]
// ----------------------------------------------------------------------------
// lsgp_pkg
// Shared widths, register indexes, reset values and the CORDIC arctangent
// table for the laser scan to grid pixel core.
// ----------------------------------------------------------------------------
package lsgp_pkg;

	// Datapath widths
	localparam int RANGE_W = 16;
	localparam int ANG16_W = 16;
	localparam int SCALE_W = 20;
	localparam int PIX_W   = 9;
	localparam int Z_W     = 32;              // CORDIC angle, 2^32 per turn
	localparam int XY_W    = 20;              // CORDIC vector, signed Q16
	localparam int ROUNDS  = 16;
	localparam int IT_W    = $clog2(ROUNDS);
	localparam int MA_W    = XY_W + RANGE_W + 1;  // range * trig, signed
	localparam int MB_W    = SCALE_W + 1;         // signed view of scale
	localparam int PR_W    = MA_W + MB_W;         // multiplier product
	localparam int T_W     = PR_W + 1;            // product plus image offset
	localparam int FRAC_W  = 32;                  // Q32 coordinate fraction

	localparam logic [XY_W-1:0]    CORDIC_GAIN   = XY_W'(39797);
	localparam logic [RANGE_W-1:0] RANGE_INVALID = 16'hFFFF;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 20;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE = 3'd4;

	// Register reset values
	localparam logic [RANGE_W-1:0] RST_RANGE_MIN   = 16'd31;
	localparam logic [RANGE_W-1:0] RST_RANGE_MAX   = 16'd896;
	localparam logic [ANG16_W-1:0] RST_ANGLE_START = 16'd0;
	localparam logic [ANG16_W-1:0] RST_ANGLE_STEP  = 16'd182;
	localparam logic [SCALE_W-1:0] RST_PIXEL_SCALE = 20'd18725;

	// Quadrant fold limits (binary angle, 16 bit)
	localparam logic [ANG16_W-1:0] ANG_QUARTER  = 16'h4000;
	localparam logic [ANG16_W-1:0] ANG_3QUARTER = 16'hC000;
	localparam logic [ANG16_W-1:0] ANG_HALF     = 16'h8000;

	// CORDIC status and result toward the sequencer
	typedef struct packed {
		logic                   done;
		logic signed [XY_W-1:0] cos_v;
		logic signed [XY_W-1:0] sin_v;
	} lsgp_trig_t;

	function automatic logic [Z_W-1:0] atan_lut(input logic [IT_W-1:0] i);
		logic [Z_W-1:0] v;
		unique case (i)
			4'd0:  v = 32'h20000000;
			4'd1:  v = 32'h12E4051E;
			4'd2:  v = 32'h09FB385B;
			4'd3:  v = 32'h051111D4;
			4'd4:  v = 32'h028B0D43;
			4'd5:  v = 32'h0145D7E1;
			4'd6:  v = 32'h00A2F61E;
			4'd7:  v = 32'h00517C55;
			4'd8:  v = 32'h0028BE53;
			4'd9:  v = 32'h00145F2F;
			4'd10: v = 32'h000A2F98;
			4'd11: v = 32'h000517CC;
			4'd12: v = 32'h00028BE6;
			4'd13: v = 32'h000145F3;
			4'd14: v = 32'h0000A2FA;
			4'd15: v = 32'h0000517D;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

[rtl/lsgp_cordic.sv]
// ----------------------------------------------------------------------------
// lsgp_cordic
// Iterative rotation-mode CORDIC: one round per cycle through a shared
// shift/add unit, giving cosine and sine of a 16 bit binary angle in Q16.
// ----------------------------------------------------------------------------
module lsgp_cordic (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lsgp_pkg::ANG16_W-1:0] angle,
	output lsgp_pkg::lsgp_trig_t        trig
);
	import lsgp_pkg::*;

	logic signed [XY_W-1:0] x_q, y_q;
	logic [Z_W-1:0]         z_q;
	logic [IT_W-1:0]        iter_q;
	logic                   busy_q, done_q, flip_q;

	logic                   fold;
	logic [ANG16_W-1:0]     ang_f;
	logic signed [XY_W-1:0] xs, ys;
	logic [Z_W-1:0]         at;

	// Fold angles beyond a quarter turn by a half turn; negate at the end
	assign fold  = (angle > ANG_QUARTER) && (angle < ANG_3QUARTER);
	assign ang_f = fold ? angle + ANG_HALF : angle;

	assign xs = x_q >>> iter_q;
	assign ys = y_q >>> iter_q;
	assign at = atan_lut(iter_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (iter_q == IT_W'(ROUNDS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= {ang_f, {(Z_W-ANG16_W){1'b0}}};
			flip_q <= fold;
		end else if (busy_q) begin
			if (!z_q[Z_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign trig.done  = done_q;
	assign trig.cos_v = flip_q ? -x_q : x_q;
	assign trig.sin_v = flip_q ? -y_q : y_q;

endmodule

[rtl/laser_scan_to_grid_pixel_core.sv]
// ----------------------------------------------------------------------------
// laser_scan_to_grid_pixel_core
// Converts laser range samples into image pixel coordinates.
// ----------------------------------------------------------------------------
// Each accepted item is one range sample. A beam angle restarts at
// angle_start on an item with scan_start set and advances by angle_step on
// every item. Samples strictly inside the range gate are rotated into x,y by
// an iterative CORDIC, multiplied by range and pixel_scale, offset to the
// image center and truncated toward zero; hit flags a pixel inside the image,
// and pixel fields are zero when hit is clear. An item runs from acceptance to a
// loaded result in these steps: 16 CORDIC rounds through one shift/add unit,
// a step to hand the rotated vector over, four products through one shared
// multiplier (range*cos, range*sin, and each times pixel_scale), then a finish
// step for the offset and bounds check. The sequencer is idle again right
// after the load, so it takes no new item until the last result is loaded.
// s_tready is high only while the sequencer is idle; a loaded result waits in
// the output register without blocking the next item, which only stalls at
// its finish step. Configuration writes take effect at once and belong to
// idle periods.
// ----------------------------------------------------------------------------
module laser_scan_to_grid_pixel_core #(
	parameter int IMAGE_DIM = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// input item
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [15:0]                    s_tdata,   // [15:0] range
	input  logic [0:0]                     s_tuser,   // [0] scan_start
	// result item
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [23:0]                    m_tdata,   // [8:0] pixel_x, [17:9] pixel_y
	output logic [0:0]                     m_tuser,   // [0] hit
	// configuration
	input  logic                           cfg_we,
	input  logic [lsgp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsgp_pkg::CFG_W-1:0]     cfg_data
);
	import lsgp_pkg::*;

	// Sequencer codes
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ROT  = 2'd1;
	localparam logic [1:0] ST_MUL  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// Multiply step codes
	localparam logic [1:0] MUL_RX = 2'd0;
	localparam logic [1:0] MUL_RY = 2'd1;
	localparam logic [1:0] MUL_SX = 2'd2;
	localparam logic [1:0] MUL_SY = 2'd3;

	// Q32 image constants
	localparam longint OFF_L = longint'(IMAGE_DIM / 2) <<< FRAC_W;
	localparam longint LIM_L = longint'(IMAGE_DIM) <<< FRAC_W;
	localparam longint NEG_L = -(longint'(1) <<< FRAC_W);
	localparam logic signed [T_W-1:0] OFF_T = T_W'(OFF_L);
	localparam logic signed [T_W-1:0] LIM_T = T_W'(LIM_L);
	localparam logic signed [T_W-1:0] NEG_T = T_W'(NEG_L);

	// Configuration registers
	logic [RANGE_W-1:0] range_min_q, range_max_q;
	logic [ANG16_W-1:0] angle_start_q, angle_step_q;
	logic [SCALE_W-1:0] pixel_scale_q;

	// Item state
	logic [ANG16_W-1:0] beam_q;
	logic [1:0]         state_q;
	logic [1:0]         mul_cnt_q;
	logic [RANGE_W-1:0] range_q;
	logic               gate_q;
	logic signed [MA_W-1:0] pr_x_q, pr_y_q;
	logic signed [T_W-1:0]  tx_q, ty_q;

	// Output register
	logic               out_valid_q;
	logic [PIX_W-1:0]   px_q, py_q;
	logic               hit_q;

	logic               accept;
	logic [ANG16_W-1:0] ang_now;
	logic               gate_now;
	lsgp_trig_t         trig;

	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [PR_W-1:0] mul_p;

	logic signed [T_W-1:0] sx, sy;
	logic                  in_x, in_y, hit_now, out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Restart the beam angle on a scan start
	assign ang_now  = s_tuser[0] ? angle_start_q : beam_q;
	assign gate_now = (s_tdata != RANGE_INVALID) && (s_tdata > range_min_q) &&
	                  (s_tdata < range_max_q);

	lsgp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.angle  (ang_now),
		.trig   (trig)
	);

	// Configuration writes; ignore unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q   <= RST_RANGE_MIN;
			range_max_q   <= RST_RANGE_MAX;
			angle_start_q <= RST_ANGLE_START;
			angle_step_q  <= RST_ANGLE_STEP;
			pixel_scale_q <= RST_PIXEL_SCALE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_MIN:   range_min_q   <= cfg_data[RANGE_W-1:0];
				REG_RANGE_MAX:   range_max_q   <= cfg_data[RANGE_W-1:0];
				REG_ANGLE_START: angle_start_q <= cfg_data[ANG16_W-1:0];
				REG_ANGLE_STEP:  angle_step_q  <= cfg_data[ANG16_W-1:0];
				REG_PIXEL_SCALE: pixel_scale_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier: select operands by step
	always_comb begin
		unique case (mul_cnt_q)
			MUL_RX: begin
				mul_a = {{(MA_W-XY_W){trig.cos_v[XY_W-1]}}, trig.cos_v};
				mul_b = $signed({{(MB_W-RANGE_W){1'b0}}, range_q});
			end
			MUL_RY: begin
				mul_a = {{(MA_W-XY_W){trig.sin_v[XY_W-1]}}, trig.sin_v};
				mul_b = $signed({{(MB_W-RANGE_W){1'b0}}, range_q});
			end
			MUL_SX: begin
				mul_a = pr_x_q;
				mul_b = $signed({1'b0, pixel_scale_q});
			end
			default: begin
				mul_a = pr_y_q;
				mul_b = $signed({1'b0, pixel_scale_q});
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Finish: offset to the image center, truncate toward zero, bound check.
	// A value in (-1, 0) truncates to column zero and stays inside.
	assign sx      = tx_q + OFF_T;
	assign sy      = ty_q + OFF_T;
	assign in_x    = (sx > NEG_T) && (sx < LIM_T);
	assign in_y    = (sy > NEG_T) && (sy < LIM_T);
	assign hit_now = gate_q && in_x && in_y;
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || m_tready);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mul_cnt_q <= MUL_RX;
			beam_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						beam_q  <= ang_now + angle_step_q;
						state_q <= ST_ROT;
					end
				end
				ST_ROT: begin
					if (trig.done) begin
						mul_cnt_q <= MUL_RX;
						state_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					mul_cnt_q <= mul_cnt_q + 1'b1;
					if (mul_cnt_q == MUL_SY) begin
						state_q <= ST_FIN;
					end
				end
				default: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
			endcase
		end
	end

	// Item payload and products
	always_ff @(posedge clk) begin
		if (accept) begin
			range_q <= s_tdata;
			gate_q  <= gate_now;
		end
		if (state_q == ST_MUL) begin
			unique case (mul_cnt_q)
				MUL_RX:  pr_x_q <= mul_p[MA_W-1:0];
				MUL_RY:  pr_y_q <= mul_p[MA_W-1:0];
				MUL_SX:  tx_q   <= {mul_p[PR_W-1], mul_p};
				default: ty_q   <= {mul_p[PR_W-1], mul_p};
			endcase
		end
	end

	// Output register: hold a result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q <= hit_now;
			px_q  <= (hit_now && !sx[T_W-1]) ? sx[FRAC_W +: PIX_W] : '0;
			py_q  <= (hit_now && !sy[T_W-1]) ? sy[FRAC_W +: PIX_W] : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(24-2*PIX_W){1'b0}}, py_q, px_q};
	assign m_tuser  = hit_q;

	// Assertions
	a_accept_starts_rot: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ROT))
		else $error("accepted item did not start the rotation");

	a_done_in_rot: assert property (@(posedge clk) disable iff (!arst_n)
		trig.done |-> (state_q == ST_ROT))
		else $error("CORDIC finished outside the rotation step");

	a_mul_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) && (mul_cnt_q == MUL_SY) |=> (state_q == ST_FIN))
		else $error("multiply sequence did not end in the finish step");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata == '0))
		else $error("result without a hit carries a nonzero pixel");

endmodule

[verif/laser_scan_to_grid_pixel_checker.sv]
// ----------------------------------------------------------------------------
// laser_scan_to_grid_pixel_checker
// Watches the sample, pixel and register channels of the scan conversion core,
// works out the pixel of every accepted sample and checks the results in order.
// ----------------------------------------------------------------------------
module laser_scan_to_grid_pixel_checker #(
	parameter int IMAGE_DIM = 512
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [15:0]                    s_tdata,   // [15:0] range
	input  logic [0:0]                     s_tuser,   // [0] scan_start
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [23:0]                    m_tdata,   // [8:0] pixel_x, [17:9] pixel_y
	input  logic [0:0]                     m_tuser,   // [0] hit
	input  logic                           cfg_we,
	input  logic [lsgp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lsgp_pkg::CFG_W-1:0]     cfg_data,
	output int                             fail_count,
	output int                             pending,
	output int                             result_count,
	output int                             hit_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import lsgp_pkg::*;

	// arctangent of 2^-i, 2^32 per turn; element i is round i
	localparam logic [ROUNDS-1:0][Z_W-1:0] ATAN_Q32 = {
		32'h0000517D, 32'h0000A2FA, 32'h000145F3, 32'h00028BE6,
		32'h000517CC, 32'h000A2F98, 32'h00145F2F, 32'h0028BE53,
		32'h00517C55, 32'h00A2F61E, 32'h0145D7E1, 32'h028B0D43,
		32'h051111D4, 32'h09FB385B, 32'h12E4051E, 32'h20000000
	};

	typedef struct packed {
		logic [RANGE_W-1:0] rng;
		logic [ANG16_W-1:0] ang;
		logic [PIX_W-1:0]   px;
		logic [PIX_W-1:0]   py;
		logic               hit;
	} grid_pixel_t;

	logic [RANGE_W-1:0] gate_lo, gate_hi;
	logic [ANG16_W-1:0] scan_angle0, beam_step, beam_angle;
	logic [SCALE_W-1:0] px_per_m;
	grid_pixel_t        pixel_q[$];

	// rotate the sample by the beam angle, scale and offset to the image center
	function automatic grid_pixel_t grid_pixel_of(input logic [RANGE_W-1:0] rng,
		input logic [ANG16_W-1:0] ang);
		grid_pixel_t p;
		logic [ANG16_W-1:0] a;
		logic [Z_W-1:0] z;
		logic flip;
		longint x, y, nx, rr, sc, tx, ty, qx, qy;
		p = '0;
		p.rng = rng;
		p.ang = ang;
		if (rng == RANGE_INVALID || rng <= gate_lo || rng >= gate_hi)
			return p;
		// fold the back half-plane onto the front and negate afterwards
		a = ang;
		flip = 1'b0;
		if (a > ANG_QUARTER && a < ANG_3QUARTER) begin
			a = a + ANG_HALF;
			flip = 1'b1;
		end
		z = {a, 16'h0000};
		x = longint'(CORDIC_GAIN);
		y = 0;
		for (int i = 0; i < ROUNDS; i++) begin
			if (!z[Z_W-1]) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ATAN_Q32[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ATAN_Q32[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		rr = longint'(rng);
		sc = longint'(px_per_m);
		tx = rr * x * sc + (longint'(IMAGE_DIM / 2) <<< 32);
		ty = rr * y * sc + (longint'(IMAGE_DIM / 2) <<< 32);
		// truncate toward zero, so (-1, 0) lands on column or row 0
		qx = (tx >= 0) ? (tx >>> 32) : -((-tx) >>> 32);
		qy = (ty >= 0) ? (ty >>> 32) : -((-ty) >>> 32);
		if (qx >= 0 && qx < IMAGE_DIM && qy >= 0 && qy < IMAGE_DIM) begin
			p.px = qx[PIX_W-1:0];
			p.py = qy[PIX_W-1:0];
			p.hit = 1'b1;
		end
		return p;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] ERROR result %0d: %s", $time, result_count, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		grid_pixel_t got, want;
		if (!arst_n) begin
			gate_lo      = RST_RANGE_MIN;
			gate_hi      = RST_RANGE_MAX;
			scan_angle0  = RST_ANGLE_START;
			beam_step    = RST_ANGLE_STEP;
			px_per_m     = RST_PIXEL_SCALE;
			beam_angle   = '0;
			pixel_q.delete();
			fail_count   = 0;
			result_count = 0;
			hit_count    = 0;
			pending     <= 0;
		end else begin
			// sample in: restart the beam on scan start, advance after every item
			if (s_tvalid && s_tready) begin
				if (s_tuser[0])
					beam_angle = scan_angle0;
				pixel_q.insert(pixel_q.size(),
					grid_pixel_of(s_tdata[RANGE_W-1:0], beam_angle));
				beam_angle = beam_angle + beam_step;
			end

			// pixel out: compare with the oldest expected item
			if (m_tvalid && m_tready) begin
				got = '0;
				got.px  = m_tdata[PIX_W-1:0];
				got.py  = m_tdata[2*PIX_W-1:PIX_W];
				got.hit = m_tuser[0];
				result_count++;
				if (pixel_q.size() == 0) begin
					report_mismatch($sformatf("x=%0d y=%0d hit=%0b arrived with nothing pending",
						got.px, got.py, got.hit));
				end else begin
					want = pixel_q.pop_front();
					if (got.hit !== want.hit)
						report_mismatch($sformatf("hit %0b, want %0b (range %0d angle %0h)",
							got.hit, want.hit, want.rng, want.ang));
					if (got.px !== want.px)
						report_mismatch($sformatf("pixel_x %0d, want %0d (range %0d angle %0h)",
							got.px, want.px, want.rng, want.ang));
					if (got.py !== want.py)
						report_mismatch($sformatf("pixel_y %0d, want %0d (range %0d angle %0h)",
							got.py, want.py, want.rng, want.ang));
					if (want.hit)
						hit_count++;
				end
			end

			// register writes; unknown indexes leave everything alone
			if (cfg_we) begin
				case (cfg_index)
					REG_RANGE_MIN:   gate_lo     = cfg_data[RANGE_W-1:0];
					REG_RANGE_MAX:   gate_hi     = cfg_data[RANGE_W-1:0];
					REG_ANGLE_START: scan_angle0 = cfg_data[ANG16_W-1:0];
					REG_ANGLE_STEP:  beam_step   = cfg_data[ANG16_W-1:0];
					REG_PIXEL_SCALE: px_per_m    = cfg_data[SCALE_W-1:0];
					default: ;
				endcase
			end

			pending <= pixel_q.size();
		end
	end

endmodule

[verif/laser_scan_to_grid_pixel_core_tb.sv]
// ----------------------------------------------------------------------------
// laser_scan_to_grid_pixel_core_tb
// Drives range samples and register settings into the scan conversion core
// with random back-pressure on both sides; the checker predicts every pixel.
// ----------------------------------------------------------------------------
module laser_scan_to_grid_pixel_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lsgp_pkg::*;

	localparam int IMAGE_DIM   = 512;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 150;
	// ~1225 items plus drains, with gaps and stalls at worst: far below this
	localparam int CYCLE_LIMIT = 400000;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [15:0]          s_tdata   = '0;   // [15:0] range
	logic [0:0]           s_tuser   = '0;   // [0] scan_start
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [23:0]          m_tdata;          // [8:0] pixel_x, [17:9] pixel_y
	logic [0:0]           m_tuser;          // [0] hit
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	int fail_count, pending, result_count, hit_count;
	int cycle_count  = 0;
	int samples_sent = 0;
	int settings_run = 0;
	int tx_gap_pct   = 0;   // chance per item of a sender gap
	int rx_stall_pct = 0;   // chance per cycle of a receiver stall
	int rx_hold      = 0;
	bit quiet        = 1'b0; // no idling on either side

	laser_scan_to_grid_pixel_core #(
		.IMAGE_DIM(IMAGE_DIM)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	laser_scan_to_grid_pixel_checker #(
		.IMAGE_DIM(IMAGE_DIM)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.result_count(result_count),
		.hit_count   (hit_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver side: stall in random bursts, never while quiet.
	always @(posedge clk) begin
		if (quiet) begin
			rx_hold  <= 0;
			m_tready <= 1'b1;
		end else if (rx_hold > 0) begin
			rx_hold  <= rx_hold - 1;
			m_tready <= 1'b0;
		end else if (rx_stall_pct > 0 && $urandom_range(0, 99) < rx_stall_pct) begin
			rx_hold  <= $urandom_range(0, 14);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycle_count, pending);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Offer one sample and hold it until accepted; then maybe leave a gap.
	// s_tvalid stays high between back-to-back items.
	task automatic send_sample(input logic [15:0] rng, input logic start);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= rng;
		s_tuser  <= start;
		do @(posedge clk); while (!s_tready);
		samples_sent++;
		if (!quiet && tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			gap = $urandom_range(1, 15);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop valid and hold off until every expected pixel has come back.
	// The first edge lets the checker count the item accepted last.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; the caller drops cfg_we after the last one.
	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// Write all five registers, with junk in the unused upper bits of the four 16 bit
	// ones, then hit an unknown index last so an aliased decode would clobber a real register.
	task automatic write_settings(input logic [15:0] rmin, input logic [15:0] rmax,
		input logic [15:0] astart, input logic [15:0] astep, input logic [19:0] scale);
		cfg_put(REG_RANGE_MIN,   {4'($urandom), rmin});
		cfg_put(REG_RANGE_MAX,   {4'($urandom), rmax});
		cfg_put(REG_ANGLE_START, {4'($urandom), astart});
		cfg_put(REG_ANGLE_STEP,  {4'($urandom), astep});
		cfg_put(REG_PIXEL_SCALE, scale);
		cfg_put(CFG_IDX_W'(REG_PIXEL_SCALE + 1 + $urandom_range(0, 2)), CFG_W'($urandom));
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_run++;
	endtask

	initial begin
		logic [15:0] rmin, rmax, astart, astep, rng;
		logic [19:0] scale;
		longint sc;
		int pick;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, gate edges and the invalid code
		tx_gap_pct   = 30;
		rx_stall_pct = 10;
		send_sample(16'd0, 1'b1);
		send_sample(16'd31, 1'b0);
		send_sample(16'd32, 1'b0);
		send_sample(16'd895, 1'b0);
		send_sample(16'd896, 1'b0);
		send_sample(RANGE_INVALID, 1'b0);
		send_sample(16'd512, 1'b0);
		send_sample(16'hFFFE, 1'b0);
		drain_results();

		// Quarter-turn steps land exactly on the fold boundaries; widest gate
		write_settings(16'h0000, 16'hFFFF, ANG_QUARTER, ANG_QUARTER, RST_PIXEL_SCALE);
		send_sample(16'd256, 1'b1);
		send_sample(16'd256, 1'b0);
		send_sample(16'd256, 1'b0);
		send_sample(16'd256, 1'b0);
		send_sample(16'd1, 1'b0);
		send_sample(16'hFFFE, 1'b0);
		drain_results();

		// Beam pointing backwards at 2 px/m: x straddles the left image edge
		write_settings(16'h0000, 16'hFFFF, ANG_HALF, 16'h0000, 20'd512);
		send_sample(16'd32822, 1'b1);
		send_sample(16'd32830, 1'b0);
		send_sample(16'd32838, 1'b0);
		send_sample(16'd32846, 1'b0);
		send_sample(16'd32854, 1'b0);
		drain_results();

		// Zero scale maps every gated sample to the center; angle wraps
		write_settings(16'h0000, 16'hFFFF, 16'h7FFF, 16'h7FFF, 20'd0);
		send_sample(16'd1000, 1'b1);
		send_sample(16'd20000, 1'b0);
		send_sample(16'd3, 1'b0);
		drain_results();

		// Adjacent gates: nothing can pass
		write_settings(16'd500, 16'd501, RST_ANGLE_START, RST_ANGLE_STEP, RST_PIXEL_SCALE);
		send_sample(16'd500, 1'b1);
		send_sample(16'd501, 1'b0);
		send_sample(RANGE_INVALID, 1'b0);
		drain_results();

		// Random scans, one register setting per phase
		for (int ph = 0; ph < PHASES; ph++) begin
			// scale so the top of the gate sits near the image border
			rmax   = 16'($urandom_range(1024, 65534));
			rmin   = 16'($urandom_range(0, 255));
			astart = 16'($urandom);
			astep  = 16'($urandom_range(1, 600));
			if ($urandom_range(0, 1))
				astep = -astep;
			sc     = (longint'(IMAGE_DIM / 2) * 65536 / rmax) * $urandom_range(80, 130) / 100;
			scale  = sc[19:0];
			case (ph)
				1: begin
					rmin   = 16'h0000;
					rmax   = 16'hFFFF;
					astart = 16'h8000;
					astep  = 16'h7FFF;
					scale  = 20'hFFFFF;
				end
				2: begin
					astart = 16'h7FFF;
					astep  = 16'h8000;
				end
				5: begin
					rmin = 16'hFFFF;
					rmax = 16'h0000;
				end
				6: begin
					rmin  = 16'h0000;
					rmax  = 16'hFFFF;
					astep = 16'($urandom);
					scale = 20'd256;
				end
				default: ;
			endcase
			write_settings(rmin, rmax, astart, astep, scale);

			// vary the back-pressure per phase; the last phase runs flat out
			if (ph == PHASES - 1) begin
				quiet        = 1'b1;
				tx_gap_pct   = 0;
				rx_stall_pct = 0;
			end else begin
				pick         = $urandom_range(0, 2);
				tx_gap_pct   = (pick == 0) ? 0 : (pick == 1) ? 20 : 50;
				pick         = $urandom_range(0, 2);
				rx_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : 15;
			end

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					if (int'(rmax) > int'(rmin) + 1)
						rng = 16'($urandom_range(int'(rmin) + 1, int'(rmax) - 1));
					else
						rng = 16'($urandom);
				end else if (pick < 80) begin
					rng = RANGE_INVALID;
				end else if (pick < 90) begin
					case ($urandom_range(0, 3))
						0:       rng = rmin;
						1:       rng = rmin + 16'd1;
						2:       rng = rmax - 16'd1;
						default: rng = rmax;
					endcase
				end else begin
					rng = 16'($urandom);
				end
				send_sample(rng, (n == 0) || ($urandom_range(0, 49) == 0));
			end
			drain_results();
		end

		// let any stray result show up before the verdict
		repeat (40) @(posedge clk);

		$display("Sent %0d range samples across %0d register settings", samples_sent,
			settings_run);
		$display("Checked %0d pixel results, %0d of them inside the image", result_count,
			hit_count);
		if (fail_count == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
